// ===== src/timed_task_scheduler_macros.svh =====
// ----------------------------------------------------------------------------
// timed_task_scheduler_macros
// Assertion macros shared by the scheduler RTL, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef TIMED_TASK_SCHEDULER_MACROS_SVH
`define TIMED_TASK_SCHEDULER_MACROS_SVH

// same-cycle implication
`define TTS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// next-cycle implication
`define TTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// ===== src/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// Codes, fixed field widths and controller states of the timed task scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tts_pkg;

    localparam int ID_W       = 32;
    localparam int INTERVAL_W = 32;
    localparam int ORDER_W    = 32;
    localparam int COUNT_W    = 5;
    localparam int KIND_W     = 3;
    localparam int REQ_W      = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD,
        REQ_REMOVE_ID,
        REQ_REMOVE_HANDLE,
        REQ_EXECUTE
    } req_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED,
        KIND_FULL,
        KIND_REMOVED,
        KIND_FIRED,
        KIND_EXEC_DONE
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_SCAN_DONE,
        ST_REINS_RD,
        ST_REINS_WR,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_DONE
    } state_t;

endpackage

// ===== src/tts_slot_mem.sv =====
// ----------------------------------------------------------------------------
// tts_slot_mem
// Slot table storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tts_slot_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== src/timed_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// timed_task_scheduler
// Timer table with add, remove by id or handle, and execute of due entries
// ----------------------------------------------------------------------------
// The slot table lives in a single-port-read memory; every search walks it
// one slot per cycle. An execute needs its own scan for the earliest entry
// for each firing, and each fired entry is read back once to reschedule
// and once to report. One request is worked at a time; the next is taken
// as soon as the final result sits in the output register.
`timescale 1ns / 1ps

module timed_task_scheduler
    import tts_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int TIME_BITS   = 48,
    parameter int HANDLE_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // time_value, repeat_interval, runnable, task_handle, entry_id
    input  logic [((TIME_BITS + INTERVAL_W + 1 + HANDLE_BITS + ID_W + 7) / 8) * 8 - 1:0] s_tdata,
    // req_type
    input  logic [REQ_W-1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // out_id, out_handle, out_runnable, count, next_time
    output logic [((ID_W + HANDLE_BITS + 1 + COUNT_W + TIME_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // kind
    output logic [KIND_W-1:0] m_tuser,
    output logic m_tlast
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_W   = ((ID_W + HANDLE_BITS + 1 + COUNT_W + TIME_BITS + 7) / 8) * 8;
    localparam int ENTRY_W = TIME_BITS + INTERVAL_W + HANDLE_BITS + ID_W + 1 + ORDER_W;

    // input word offsets
    localparam int I_IVL = TIME_BITS;
    localparam int I_RUN = I_IVL + INTERVAL_W;
    localparam int I_HDL = I_RUN + 1;
    localparam int I_ID  = I_HDL + HANDLE_BITS;

    state_t state_reg, state_next;

    // request
    req_t                   req_reg;
    logic [TIME_BITS-1:0]   tval_reg;
    logic [INTERVAL_W-1:0]  ival_reg;
    logic                   run_reg;
    logic [HANDLE_BITS-1:0] hdl_reg;
    logic [ID_W-1:0]        eid_reg;

    // table control
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [ID_W-1:0]        id_cnt_reg;
    logic [ORDER_W-1:0]     order_cnt_reg;

    // scan
    logic [IDX_W-1:0]       scan_cnt_reg;
    logic                   cmp_v_reg;
    logic [IDX_W-1:0]       cmp_idx_reg;
    logic                   final_reg;
    logic                   found_reg;
    logic [TIME_BITS-1:0]   best_due_reg;
    logic [ORDER_W-1:0]     best_order_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic [CNT_W-1:0]       removed_reg;

    // firing list
    logic [IDX_W-1:0]       fired_reg [TABLE_DEPTH];
    logic [CNT_W-1:0]       nf_reg;
    logic [CNT_W-1:0]       k_reg;

    // result
    kind_t                  res_kind_reg;
    logic [ID_W-1:0]        res_id_reg;
    logic [CNT_W-1:0]       res_count_reg;
    logic [TIME_BITS-1:0]   next_time_reg;

    // output register
    logic                   out_valid_reg;
    kind_t                  out_kind_reg;
    logic [ID_W-1:0]        out_id_reg;
    logic [HANDLE_BITS-1:0] out_hdl_reg;
    logic                   out_run_reg;
    logic [COUNT_W-1:0]     out_count_reg;
    logic [TIME_BITS-1:0]   out_time_reg;
    logic                   out_last_reg;

    // memory ports
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [ENTRY_W-1:0]     mem_wdata;
    logic [IDX_W-1:0]       mem_raddr;
    logic [ENTRY_W-1:0]     mem_rdata;

    // read entry fields
    logic [TIME_BITS-1:0]   rd_due;
    logic [INTERVAL_W-1:0]  rd_ival;
    logic [HANDLE_BITS-1:0] rd_hdl;
    logic [ID_W-1:0]        rd_id;
    logic                   rd_run;
    logic [ORDER_W-1:0]     rd_order;

    logic                   out_free;
    logic                   load_fired;
    logic                   load_done;
    logic                   final_start;
    logic                   due_hit;
    logic                   has_free;
    logic [IDX_W-1:0]       free_idx;
    logic                   cmp_match;
    logic                   cmp_better;
    logic                   hdl_match;
    logic [TIME_BITS:0]     resched_sum;
    logic [TIME_BITS-1:0]   resched_due;
    logic [IDX_W-1:0]       fired_k;

    tts_slot_mem #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign {rd_due, rd_ival, rd_hdl, rd_id, rd_run, rd_order} = mem_rdata;

    // first free slot, lowest index wins
    always_comb
    begin
        has_free = 1'b0;
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                has_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // scan compare on the word read last cycle
    assign cmp_match = valid_reg[cmp_idx_reg] &&
                       (final_reg || req_reg == REQ_EXECUTE ||
                        (req_reg == REQ_REMOVE_ID && rd_id == eid_reg));
    assign cmp_better = !found_reg || rd_due < best_due_reg ||
                        (rd_due == best_due_reg && rd_order < best_order_reg);
    assign hdl_match = cmp_v_reg && !final_reg && req_reg == REQ_REMOVE_HANDLE &&
                       valid_reg[cmp_idx_reg] && hdl_reg != '0 && rd_hdl == hdl_reg;

    assign due_hit = found_reg && best_due_reg <= tval_reg;
    assign fired_k = fired_reg[k_reg[IDX_W-1:0]];

    // saturating reschedule time
    assign resched_sum = {1'b0, tval_reg} + (TIME_BITS + 1)'(rd_ival);
    assign resched_due = resched_sum[TIME_BITS] ? '1 : resched_sum[TIME_BITS-1:0];

    assign out_free = !out_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (req_t'(s_tuser) == REQ_ADD) ? ST_ADD : ST_SCAN_INIT;
                end
            end
            ST_ADD:       state_next = ST_SCAN_INIT;
            ST_SCAN_INIT: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_cnt_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_SCAN_LAST;
                end
            end
            ST_SCAN_LAST: state_next = ST_SCAN_DONE;
            ST_SCAN_DONE:
            begin
                if (final_reg)
                begin
                    state_next = (req_reg == REQ_EXECUTE && nf_reg != '0) ?
                                 ST_EMIT_RD : ST_EMIT_DONE;
                end
                else if (req_reg == REQ_EXECUTE && !due_hit && nf_reg != '0)
                begin
                    state_next = ST_REINS_RD;
                end
                else
                begin
                    state_next = ST_SCAN_INIT;
                end
            end
            ST_REINS_RD:  state_next = ST_REINS_WR;
            ST_REINS_WR:
            begin
                state_next = (k_reg + CNT_W'(1) == nf_reg) ? ST_SCAN_INIT : ST_REINS_RD;
            end
            ST_EMIT_RD:   state_next = ST_EMIT_LD;
            ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    state_next = (k_reg + CNT_W'(1) == nf_reg) ? ST_EMIT_DONE : ST_EMIT_RD;
                end
            end
            ST_EMIT_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // controller outputs
    always_comb
    begin
        s_tready    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = free_idx;
        mem_wdata   = {tval_reg, ival_reg, hdl_reg, id_cnt_reg + ID_W'(1), run_reg,
                       order_cnt_reg};
        mem_raddr   = scan_cnt_reg;
        load_fired  = 1'b0;
        load_done   = 1'b0;
        final_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_ADD:
            begin
                mem_we      = has_free;
                final_start = 1'b1;
            end
            ST_SCAN_DONE:
            begin
                final_start = !final_reg &&
                              !(req_reg == REQ_EXECUTE && (due_hit || nf_reg != '0));
            end
            ST_REINS_RD:
            begin
                mem_raddr = fired_k;
            end
            ST_REINS_WR:
            begin
                mem_raddr   = fired_k;
                mem_we      = rd_ival != '0;
                mem_waddr   = fired_k;
                mem_wdata   = {resched_due, rd_ival, rd_hdl, rd_id, rd_run, order_cnt_reg};
                final_start = k_reg + CNT_W'(1) == nf_reg;
            end
            ST_EMIT_RD, ST_EMIT_LD:
            begin
                mem_raddr  = fired_k;
                load_fired = state_reg == ST_EMIT_LD && out_free;
            end
            ST_EMIT_DONE:
            begin
                load_done = out_free;
            end
            default:
            begin
                mem_raddr = scan_cnt_reg;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // request capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg <= REQ_ADD;
        end
        else if (s_tvalid && s_tready)
        begin
            req_reg <= req_t'(s_tuser);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            tval_reg <= s_tdata[I_IVL-1:0];
            ival_reg <= s_tdata[I_RUN-1:I_IVL];
            run_reg  <= s_tdata[I_RUN];
            hdl_reg  <= s_tdata[I_ID-1:I_HDL];
            eid_reg  <= s_tdata[I_ID+ID_W-1:I_ID];
        end
    end

    // table control and sequencing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            id_cnt_reg    <= '0;
            order_cnt_reg <= '0;
            scan_cnt_reg  <= '0;
            cmp_v_reg     <= 1'b0;
            final_reg     <= 1'b0;
            found_reg     <= 1'b0;
            removed_reg   <= '0;
            nf_reg        <= '0;
            k_reg         <= '0;
        end
        else
        begin
            cmp_v_reg <= state_reg == ST_SCAN;

            // request start
            if (s_tvalid && s_tready)
            begin
                nf_reg    <= '0;
                final_reg <= 1'b0;
            end

            if (final_start)
            begin
                final_reg <= 1'b1;
            end

            // add
            if (state_reg == ST_ADD && has_free)
            begin
                valid_reg[free_idx] <= 1'b1;
                id_cnt_reg          <= id_cnt_reg + ID_W'(1);
                order_cnt_reg       <= order_cnt_reg + ORDER_W'(1);
            end

            // scan walk
            if (state_reg == ST_SCAN_INIT)
            begin
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
                removed_reg  <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
            end

            if (cmp_v_reg && cmp_match && cmp_better)
            begin
                found_reg <= 1'b1;
            end

            // remove by handle clears as the walk passes
            if (hdl_match)
            begin
                valid_reg[cmp_idx_reg] <= 1'b0;
                removed_reg            <= removed_reg + CNT_W'(1);
            end

            // scan outcome
            if (state_reg == ST_SCAN_DONE)
            begin
                k_reg <= '0;
                if (!final_reg && found_reg &&
                    (req_reg == REQ_REMOVE_ID || (req_reg == REQ_EXECUTE && due_hit)))
                begin
                    valid_reg[best_idx_reg] <= 1'b0;
                end
                if (!final_reg && req_reg == REQ_EXECUTE && due_hit)
                begin
                    nf_reg <= nf_reg + CNT_W'(1);
                end
            end

            // reinsertion of recurring entries
            if (state_reg == ST_REINS_WR)
            begin
                k_reg <= k_reg + CNT_W'(1);
                if (rd_ival != '0)
                begin
                    valid_reg[fired_k] <= 1'b1;
                    order_cnt_reg      <= order_cnt_reg + ORDER_W'(1);
                end
            end

            if (load_fired)
            begin
                k_reg <= k_reg + CNT_W'(1);
            end
        end
    end

    // scan datapath and result words
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_cnt_reg;

        if (cmp_v_reg && cmp_match && cmp_better)
        begin
            best_due_reg   <= rd_due;
            best_order_reg <= rd_order;
            best_idx_reg   <= cmp_idx_reg;
        end

        if (state_reg == ST_SCAN_DONE && !final_reg && req_reg == REQ_EXECUTE && due_hit)
        begin
            fired_reg[nf_reg[IDX_W-1:0]] <= best_idx_reg;
        end

        if (state_reg == ST_ADD)
        begin
            res_kind_reg  <= has_free ? KIND_ADDED : KIND_FULL;
            res_id_reg    <= has_free ? id_cnt_reg + ID_W'(1) : '0;
            res_count_reg <= '0;
        end

        if (state_reg == ST_SCAN_DONE)
        begin
            if (final_reg)
            begin
                next_time_reg <= found_reg ? best_due_reg : '1;
                if (req_reg == REQ_EXECUTE)
                begin
                    res_kind_reg  <= KIND_EXEC_DONE;
                    res_id_reg    <= '0;
                    res_count_reg <= nf_reg;
                end
            end
            else if (req_reg == REQ_REMOVE_ID || req_reg == REQ_REMOVE_HANDLE)
            begin
                res_kind_reg  <= KIND_REMOVED;
                res_id_reg    <= '0;
                res_count_reg <= (req_reg == REQ_REMOVE_ID) ? CNT_W'(found_reg) : removed_reg;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_fired || load_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_fired)
        begin
            out_kind_reg  <= KIND_FIRED;
            out_id_reg    <= rd_id;
            out_hdl_reg   <= rd_hdl;
            out_run_reg   <= rd_run;
            out_count_reg <= COUNT_W'(k_reg + CNT_W'(1));
            out_time_reg  <= next_time_reg;
            out_last_reg  <= 1'b0;
        end
        else if (load_done)
        begin
            out_kind_reg  <= res_kind_reg;
            out_id_reg    <= res_id_reg;
            out_hdl_reg   <= '0;
            out_run_reg   <= 1'b0;
            out_count_reg <= COUNT_W'(res_count_reg);
            out_time_reg  <= next_time_reg;
            out_last_reg  <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_W'({out_time_reg, out_count_reg, out_run_reg, out_hdl_reg,
                              out_id_reg});

    // checks
`include "timed_task_scheduler_macros.svh"

    `TTS_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready)
    `TTS_ASSERT_SAME(a_last_marks_end, m_tvalid, m_tlast == (m_tuser != KIND_FIRED))
    `TTS_ASSERT_SAME(a_fired_count, m_tvalid && m_tuser == KIND_FIRED, m_tdata[ID_W+HANDLE_BITS+1+:COUNT_W] != '0)
    `TTS_ASSERT_SAME(a_no_idle_write, mem_we, state_reg != ST_IDLE)

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the timed task scheduler: add, remove by id or handle, and execute
// requests go in over the input stream, and every result word is compared
// field by field with a prediction of the timer table kept in a scoreboard
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
    import tts_pkg::*;
();

    localparam int DEPTH  = 16;
    localparam int TBITS  = 48;
    localparam int HBITS  = 16;
    localparam int SDATA_W = ((TBITS + INTERVAL_W + 1 + HBITS + ID_W + 7) / 8) * 8;
    localparam int MDATA_W = ((ID_W + HBITS + 1 + COUNT_W + TBITS + 7) / 8) * 8;
    localparam logic [TBITS-1:0] TIME_MAX = '1;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   id;
        logic [HBITS-1:0]  handle;
        logic              run;
        logic [COUNT_W-1:0] count;
        logic [TBITS-1:0]  next_time;
        logic              last;
    } sched_word_t;

    // timer table mirror and queue of expected result words
    class sched_scoreboard;
        bit                    used[DEPTH];
        logic [TBITS-1:0]      due[DEPTH];
        logic [INTERVAL_W-1:0] period[DEPTH];
        logic [HBITS-1:0]      hnd[DEPTH];
        logic [ID_W-1:0]       ident[DEPTH];
        bit                    runf[DEPTH];
        logic [ORDER_W-1:0]    seq[DEPTH];
        logic [ID_W-1:0]       id_ctr;
        logic [ORDER_W-1:0]    seq_ctr;
        sched_word_t           pending_words[$];
        int                    errors;

        function new();
            foreach (used[i]) used[i] = 0;
            id_ctr = '0;
            seq_ctr = '0;
            errors = 0;
        endfunction

        function bit earlier(int a, int b);
            return due[a] < due[b] || (due[a] == due[b] && seq[a] < seq[b]);
        endfunction

        function int earliest();
            int best;
            best = -1;
            for (int i = 0; i < DEPTH; i++)
                if (used[i] && (best < 0 || earlier(i, best)))
                    best = i;
            return best;
        endfunction

        function sched_word_t mk(kind_t k, logic [ID_W-1:0] id, logic [HBITS-1:0] h,
                                 bit r, int cnt, bit lst);
            sched_word_t w;
            w.kind = k;
            w.id = id;
            w.handle = h;
            w.run = r;
            w.count = cnt[COUNT_W-1:0];
            w.next_time = '0;
            w.last = lst;
            return w;
        endfunction

        // apply one accepted request and queue its result words
        function void note_request(req_t req, logic [TBITS-1:0] tval,
                                   logic [INTERVAL_W-1:0] ival, bit run,
                                   logic [HBITS-1:0] h, logic [ID_W-1:0] eid);
            sched_word_t words[$];
            int free_slot, best, removed, s, e;
            int fired[$];
            logic [TBITS-1:0] nt;
            case (req)
                REQ_ADD:
                begin
                    free_slot = -1;
                    for (int i = DEPTH - 1; i >= 0; i--)
                        if (!used[i]) free_slot = i;
                    if (free_slot < 0)
                        words.insert(words.size(), mk(KIND_FULL, '0, '0, 0, 0, 1));
                    else
                    begin
                        id_ctr++;
                        used[free_slot] = 1;
                        due[free_slot] = tval;
                        period[free_slot] = ival;
                        hnd[free_slot] = h;
                        ident[free_slot] = id_ctr;
                        runf[free_slot] = run;
                        seq[free_slot] = seq_ctr++;
                        words.insert(words.size(), mk(KIND_ADDED, id_ctr, '0, 0, 0, 1));
                    end
                end
                REQ_REMOVE_ID:
                begin
                    best = -1;
                    for (int i = 0; i < DEPTH; i++)
                        if (used[i] && ident[i] == eid && (best < 0 || earlier(i, best)))
                            best = i;
                    if (best >= 0) used[best] = 0;
                    words.insert(words.size(), mk(KIND_REMOVED, '0, '0, 0, best >= 0, 1));
                end
                REQ_REMOVE_HANDLE:
                begin
                    removed = 0;
                    if (h != 0)
                        for (int i = 0; i < DEPTH; i++)
                            if (used[i] && hnd[i] == h)
                            begin
                                used[i] = 0;
                                removed++;
                            end
                    words.insert(words.size(), mk(KIND_REMOVED, '0, '0, 0, removed, 1));
                end
                default:
                begin
                    forever
                    begin
                        s = earliest();
                        if (s < 0 || due[s] > tval) break;
                        used[s] = 0;
                        fired.insert(fired.size(), s);
                        words.insert(words.size(), mk(KIND_FIRED, ident[s], hnd[s], runf[s],
                                                      fired.size(), 0));
                    end
                    // recurring entries come back at now plus interval, saturated
                    foreach (fired[k])
                    begin
                        s = fired[k];
                        if (period[s] != 0)
                        begin
                            due[s] = ({16'd0, period[s]} > TIME_MAX - tval) ?
                                     TIME_MAX : tval + period[s];
                            seq[s] = seq_ctr++;
                            used[s] = 1;
                        end
                    end
                    words.insert(words.size(),
                                 mk(KIND_EXEC_DONE, '0, '0, 0, fired.size(), 1));
                end
            endcase
            e = earliest();
            nt = (e < 0) ? TIME_MAX : due[e];
            foreach (words[k])
            begin
                words[k].next_time = nt;
                pending_words.insert(pending_words.size(), words[k]);
            end
        endfunction

        // compare one accepted result word with the oldest expectation
        function void check_result(sched_word_t got);
            sched_word_t exp_w;
            if (pending_words.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: %p", got);
                return;
            end
            exp_w = pending_words[0];
            pending_words.delete(0);
            if (got !== exp_w)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %p, got %p", exp_w, got);
            end
        endfunction

        function int pending();
            return pending_words.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    // time_value, repeat_interval, runnable, task_handle, entry_id
    logic [SDATA_W-1:0] s_tdata;
    // req_type
    logic [REQ_W-1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    // out_id, out_handle, out_runnable, count, next_time
    logic [MDATA_W-1:0] m_tdata;
    // kind
    logic [KIND_W-1:0] m_tuser;
    logic m_tlast;

    sched_scoreboard sb;
    int  hold_request;
    bit  quiet;
    logic [TBITS-1:0] now_us;

    timed_task_scheduler u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #8ms;
        $display("testbench: done, errors");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int stall;
        sched_word_t got;
        stall = 0;
        m_tready = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.kind = kind_t'(m_tuser);
                got.id = m_tdata[31:0];
                got.handle = m_tdata[47:32];
                got.run = m_tdata[48];
                got.count = m_tdata[53:49];
                got.next_time = m_tdata[101:54];
                got.last = m_tlast;
                sb.check_result(got);
                stall = quiet ? 0 : $urandom_range(0, 7);
            end
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            if (stall > 0)
            begin
                stall--;
                m_tready <= 0;
            end
            else
                m_tready <= 1;
        end
    end

    // offer one request and wait until it is taken
    task automatic send_req(req_t req, logic [TBITS-1:0] tval, logic [INTERVAL_W-1:0] ival,
                            bit run, logic [HBITS-1:0] h, logic [ID_W-1:0] eid);
        int gap;
        logic [SDATA_W-1:0] data_word;
        gap = quiet ? 0 : $urandom_range(0, 7);
        data_word = '0;
        data_word[TBITS-1:0] = tval;
        data_word[79:48] = ival;
        data_word[80] = run;
        data_word[96:81] = h;
        data_word[128:97] = eid;
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= req;
        s_tdata <= data_word;
        do @(posedge clk); while (!s_tready);
        sb.note_request(req, tval, ival, run, h, eid);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic random_req();
        int pick;
        logic [TBITS-1:0] t;
        logic [INTERVAL_W-1:0] iv;
        logic [HBITS-1:0] h;
        logic [ID_W-1:0] eid;
        bit r;
        pick = $urandom_range(0, 99);
        r = 1'($urandom_range(0, 1));
        t = now_us + TBITS'($urandom_range(0, 300));
        if ($urandom_range(0, 9) == 0)
            t = TBITS'({$urandom, $urandom});
        iv = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 200);
        if ($urandom_range(0, 11) == 0)
            iv = $urandom;
        h = ($urandom_range(0, 5) == 0) ? HBITS'($urandom) : HBITS'($urandom_range(0, 7));
        eid = ($urandom_range(0, 5) == 0 || sb.id_ctr == 0) ? $urandom :
              sb.id_ctr - $urandom_range(0, 20);
        if (pick < 42)
            send_req(REQ_ADD, t, iv, r, h, $urandom);
        else if (pick < 55)
            send_req(REQ_REMOVE_ID, TBITS'({$urandom, $urandom}), $urandom, r,
                     HBITS'($urandom), eid);
        else if (pick < 65)
            send_req(REQ_REMOVE_HANDLE, TBITS'({$urandom, $urandom}), $urandom, r, h,
                     $urandom);
        else
        begin
            now_us = now_us + TBITS'($urandom_range(0, 200));
            t = ($urandom_range(0, 29) == 0) ? TIME_MAX : now_us;
            send_req(REQ_EXECUTE, t, $urandom, r, HBITS'($urandom), $urandom);
        end
    endtask

    // stimulus
    initial
    begin
        sb = new();
        hold_request = 0;
        quiet = 0;
        now_us = '0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = REQ_ADD;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: field extremes, table full, zero handle, saturation
        send_req(REQ_EXECUTE, '0, '0, 0, '0, '0);
        send_req(REQ_ADD, '0, '0, 0, '0, '0);
        send_req(REQ_ADD, TIME_MAX, 32'hFFFF_FFFF, 1, 16'hFFFF, 32'hFFFF_FFFF);
        send_req(REQ_ADD, 48'd10, 32'd5, 1, 16'd3, '0);
        send_req(REQ_ADD, 48'd10, 32'hFFFF_FFFF, 0, 16'd3, '0);
        for (int i = 0; i < 13; i++)
            send_req(REQ_ADD, 48'd20 + TBITS'(i % 3), INTERVAL_W'(i % 2), 1'(i % 2),
                     16'd5, '0);
        send_req(REQ_ADD, 48'd1, 32'd1, 1, 16'd7, '0);
        send_req(REQ_REMOVE_ID, '0, '0, 0, '0, 32'hFFFF_FFFF);
        send_req(REQ_REMOVE_ID, '0, '0, 0, '0, 32'd2);
        send_req(REQ_REMOVE_HANDLE, '0, '0, 0, '0, '0);
        send_req(REQ_EXECUTE, 48'd10, '0, 0, '0, '0);
        send_req(REQ_EXECUTE, TIME_MAX - 48'd3, '0, 0, '0, '0);
        send_req(REQ_EXECUTE, TIME_MAX, '0, 0, '0, '0);
        send_req(REQ_REMOVE_HANDLE, '0, '0, 0, 16'd5, '0);
        send_req(REQ_REMOVE_HANDLE, '0, '0, 0, 16'd3, '0);
        send_req(REQ_REMOVE_HANDLE, '0, '0, 0, 16'hFFFF, '0);
        drain();

        // random phases, one under a long receiver hold-off, one without idling
        for (int ph = 0; ph < 6; ph++)
        begin
            quiet = (ph == 3);
            if (ph == 1)
                hold_request = 400;
            for (int n = 0; n < 50; n++)
                random_req();
            if (ph == 2)
            begin
                send_req(REQ_REMOVE_HANDLE, '0, '0, 0, 16'd0, '0);
                for (int k = 1; k < 8; k++)
                    send_req(REQ_REMOVE_HANDLE, '0, '0, 0, HBITS'(k), '0);
            end
            drain();
        end
        quiet = 0;

        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
